// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define KNN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("knn check failed");

// Check a property on every rising clock edge, reset included.
`define KNN_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("knn reset check failed");

`endif

// ===== rtl/knn_pkg.sv =====
// Shared widths, constants and types of the splay predictor.
`default_nettype none
package knn_pkg;
   localparam int CAB_W        = 5;
   localparam int MAX_CABINETS = 16;
   localparam int VAL_W        = 16;
   localparam int SQ_SUM_W     = 34;
   localparam int SQ_W         = 50;
   localparam int ROOT_W       = 25;
   localparam int W_W          = 26;
   localparam int SUMW_W       = 29;
   localparam int APROD_W      = 43;
   localparam int ACC_W        = 46;
   localparam int DIV_NUM_W    = 50;
   localparam int DIV_DEN_W    = 38;
   localparam int TENTHS_W     = 12;
   localparam int EPS_Q16      = 66;
   localparam int FB_SCALE     = 160;

   typedef logic [ROOT_W-1:0]    root_type;
   typedef logic [SQ_W-1:0]      radicand_type;
   typedef logic [DIV_NUM_W-1:0] div_num_type;
   typedef logic [DIV_DEN_W-1:0] div_den_type;
endpackage
`default_nettype wire

// ===== rtl/knn_idw_splay_predictor.sv =====
// Top level: record store, nearest-neighbour scan and weighted-mean sequencer.
//
// Usage. The req_ channel carries one beat per item. command 0 appends one
// splay angle to the record being built; the beat with last high closes the
// record and stores it with that beat's cabinets, height and tilt. command 1
// queries: the block returns cabinets-1 rsp_ beats, the last flagged by
// rsp_last_result, either the inverse-distance mean of the three nearest
// stored records (rsp_from_memory high) or the fallback curve.
// An insert beat is taken while idle and the block stays idle. A query
// scans every stored record; one with the same cabinet count and length
// goes through the square-root unit (25 steps). Each neighbour weight and
// each result angle then takes a pass of the 50-step shared divider, as
// does each fallback angle. req_ready is high only between items; the
// block works on one item at a time. When the receiver stalls, the result
// beat holds on rsp_ and the sequencer waits. Reset empties the record
// table at once (no clearing pass) and drops any partly built record and
// any query in progress.
`default_nettype none
module knn_idw_splay_predictor #(
   parameter int MAX_RECORDS  = 64,
   parameter int NEIGHBOURS   = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [4:0]  req_cabinets,
   input  wire logic signed [15:0] req_height,
   input  wire logic signed [15:0] req_tilt,
   input  wire logic signed [15:0] req_splay_value,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [11:0] rsp_splay_tenths,
   output logic             rsp_from_memory,
   output logic             rsp_last_result
);
   localparam int NB      = NEIGHBOURS;
   localparam int SPLAYS  = knn_pkg::MAX_CABINETS - 1;
   localparam int CNT_W   = $clog2(MAX_RECORDS + 1);
   localparam int IDX_W   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int FILL_W  = $clog2(SPLAYS + 1);
   localparam int ADEPTH  = MAX_RECORDS * SPLAYS;
   localparam int AADDR_W = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
   localparam int KEY_W   = knn_pkg::CAB_W + 2 * knn_pkg::VAL_W + FILL_W;
   localparam int FND_W   = $clog2(NB + 1);
   localparam int KI_W    = (NB > 1) ? $clog2(NB) : 1;
   localparam int CW      = knn_pkg::CAB_W;
   localparam int VW      = knn_pkg::VAL_W;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_SCAN   = 5'd1;
   localparam logic [4:0] S_KEY    = 5'd2;
   localparam logic [4:0] S_SQH    = 5'd3;
   localparam logic [4:0] S_SQT    = 5'd4;
   localparam logic [4:0] S_RSTART = 5'd5;
   localparam logic [4:0] S_ROOT   = 5'd6;
   localparam logic [4:0] S_WEIGHT = 5'd7;
   localparam logic [4:0] S_WDIV   = 5'd8;
   localparam logic [4:0] S_ASTART = 5'd9;
   localparam logic [4:0] S_AREAD  = 5'd10;
   localparam logic [4:0] S_AMUL   = 5'd11;
   localparam logic [4:0] S_AADD   = 5'd12;
   localparam logic [4:0] S_ONUM   = 5'd13;
   localparam logic [4:0] S_OSTART = 5'd14;
   localparam logic [4:0] S_ODIV   = 5'd15;
   localparam logic [4:0] S_FSTART = 5'd16;
   localparam logic [4:0] S_FDIV   = 5'd17;
   localparam logic [4:0] S_OUT    = 5'd18;

   // control
   logic [4:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  rec_ff, rec_in;
   logic [FND_W-1:0]  found_ff, found_in;
   logic [FND_W-1:0]  k_ff, k_in;
   logic [CW-1:0]     s_ff, s_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // query payload
   logic [CW-1:0]              qcab_ff, qcab_in;
   logic [VW-1:0]              qh_ff, qh_in;
   logic [VW-1:0]              qt_ff, qt_in;
   logic [CW-1:0]              n_ff, n_in;
   logic [2*CW-1:0]            m2_ff, m2_in;
   logic signed [VW:0]         dh_ff, dh_in;
   logic signed [VW:0]         dt_ff, dt_in;
   logic [2*VW:0]              hsq_ff, hsq_in;
   logic [knn_pkg::SQ_SUM_W-1:0] sq_ff, sq_in;
   knn_pkg::root_type          dist_ff [NB];
   knn_pkg::root_type          dist_in [NB];
   logic [IDX_W-1:0]           idx_ff [NB];
   logic [IDX_W-1:0]           idx_in [NB];
   logic [knn_pkg::W_W-1:0]    wt_ff [NB];
   logic [knn_pkg::W_W-1:0]    wt_in [NB];
   logic [knn_pkg::SUMW_W-1:0] sumw_ff, sumw_in;
   logic signed [knn_pkg::APROD_W-1:0] aprod_ff, aprod_in;
   logic signed [knn_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic [knn_pkg::ACC_W-1:0]  mag_ff, mag_in;
   logic [knn_pkg::TENTHS_W-1:0] tenths_ff, tenths_in;
   logic                       mem_ff, mem_in;
   logic                       last_ff, last_in;

   // memories
   logic               key_we;
   logic [IDX_W-1:0]   key_waddr, key_raddr;
   logic [KEY_W-1:0]   key_wdata, key_rdata;
   logic               ang_we;
   logic [AADDR_W-1:0] ang_waddr, ang_raddr;
   logic [VW-1:0]      ang_rdata;

   // shared units
   logic                  div_start, div_done;
   knn_pkg::div_num_type  div_num, div_quot;
   knn_pkg::div_den_type  div_den;
   logic                  sqrt_start, sqrt_done;
   knn_pkg::root_type     sqrt_root;

   // key fields of the record being read
   logic [FILL_W-1:0] k_len;
   logic [VW-1:0]     k_tilt, k_height;
   logic [CW-1:0]     k_cab;
   logic [KI_W-1:0]   ki;
   logic [FND_W-1:0]  pos;
   logic              cab_ok;

   assign k_len    = key_rdata[FILL_W-1:0];
   assign k_tilt   = key_rdata[FILL_W+VW-1:FILL_W];
   assign k_height = key_rdata[FILL_W+2*VW-1:FILL_W+VW];
   assign k_cab    = key_rdata[KEY_W-1:FILL_W+2*VW];
   assign ki       = k_ff[KI_W-1:0];
   assign cab_ok   = (req_cabinets > 5'd1) &&
                     (32'(req_cabinets) <= knn_pkg::MAX_CABINETS);

   knn_ram #(.WIDTH(KEY_W), .DEPTH(MAX_RECORDS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   knn_ram #(.WIDTH(VW), .DEPTH(ADEPTH)) u_ang_ram (
      .clock   (clock),
      .wr_en   (ang_we),
      .wr_addr (ang_waddr),
      .wr_data (req_splay_value),
      .rd_addr (ang_raddr),
      .rd_data (ang_rdata)
   );

   knn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   knn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({sq_ff, 16'b0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // rank of a new distance: entries at or below it stay ahead (ties keep
   // the earlier record first)
   always_comb begin
      pos = '0;
      for (int i = 0; i < NB; i++) begin
         if ((FND_W'(i) < found_ff) && (dist_ff[i] <= sqrt_root)) begin
            pos = pos + FND_W'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      rec_in       = rec_ff;
      found_in     = found_ff;
      k_in         = k_ff;
      s_in         = s_ff;
      rsp_valid_in = rsp_valid_ff;
      qcab_in      = qcab_ff;
      qh_in        = qh_ff;
      qt_in        = qt_ff;
      n_in         = n_ff;
      m2_in        = m2_ff;
      dh_in        = dh_ff;
      dt_in        = dt_ff;
      hsq_in       = hsq_ff;
      sq_in        = sq_ff;
      dist_in      = dist_ff;
      idx_in       = idx_ff;
      wt_in        = wt_ff;
      sumw_in      = sumw_ff;
      aprod_in     = aprod_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      tenths_in    = tenths_ff;
      mem_in       = mem_ff;
      last_in      = last_ff;

      key_we     = 1'b0;
      key_waddr  = count_ff[IDX_W-1:0];
      key_wdata  = {req_cabinets, req_height, req_tilt, FILL_W'(fill_ff + FILL_W'(1))};
      key_raddr  = rec_ff[IDX_W-1:0];
      ang_we     = 1'b0;
      ang_waddr  = AADDR_W'(32'(count_ff) * SPLAYS + 32'(fill_ff));
      ang_raddr  = AADDR_W'(32'(idx_ff[ki]) * SPLAYS + 32'(s_ff));
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;
      sqrt_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_command) begin
               // append one angle; a full table only drops the write
               if (32'(fill_ff) < SPLAYS) begin
                  ang_we  = (32'(count_ff) < MAX_RECORDS);
                  fill_in = fill_ff + FILL_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  if (!ovf_ff && (32'(fill_ff) < SPLAYS) &&
                      (32'(count_ff) < MAX_RECORDS) && cab_ok) begin
                     key_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  fill_in = '0;
                  ovf_in  = 1'b0;
               end
            end else if (req_valid && cab_ok) begin
               qcab_in  = req_cabinets;
               qh_in    = req_height;
               qt_in    = req_tilt;
               n_in     = req_cabinets - CW'(1);
               m2_in    = (2*CW)'(req_cabinets - CW'(1)) * (2*CW)'(req_cabinets - CW'(1));
               rec_in   = '0;
               found_in = '0;
               sumw_in  = '0;
               k_in     = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rec_ff == count_ff) begin
               k_in     = '0;
               state_in = S_WEIGHT;
            end else begin
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            if ((k_cab == qcab_ff) && (8'(k_len) == 8'(n_ff))) begin
               dh_in    = $signed({k_height[VW-1], k_height}) - $signed({qh_ff[VW-1], qh_ff});
               dt_in    = $signed({k_tilt[VW-1], k_tilt}) - $signed({qt_ff[VW-1], qt_ff});
               state_in = S_SQH;
            end else begin
               rec_in   = rec_ff + CNT_W'(1);
               state_in = S_SCAN;
            end
         end
         S_SQH: begin
            hsq_in   = (2*VW+1)'(dh_ff * dh_ff);
            state_in = S_SQT;
         end
         S_SQT: begin
            sq_in    = knn_pkg::SQ_SUM_W'(hsq_ff) +
                       {(knn_pkg::SQ_SUM_W-1)'(dt_ff * dt_ff), 1'b0};
            state_in = S_RSTART;
         end
         S_RSTART: begin
            sqrt_start = 1'b1;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            if (sqrt_done) begin
               if (32'(pos) < NB) begin
                  for (int i = 1; i < NB; i++) begin
                     if (FND_W'(i) > pos) begin
                        dist_in[i] = dist_ff[i-1];
                        idx_in[i]  = idx_ff[i-1];
                     end
                  end
                  for (int i = 0; i < NB; i++) begin
                     if (FND_W'(i) == pos) begin
                        dist_in[i] = sqrt_root;
                        idx_in[i]  = rec_ff[IDX_W-1:0];
                     end
                  end
                  if (32'(found_ff) < NB) begin
                     found_in = found_ff + FND_W'(1);
                  end
               end
               rec_in   = rec_ff + CNT_W'(1);
               state_in = S_SCAN;
            end
         end
         S_WEIGHT: begin
            s_in = '0;
            if (found_ff == '0) begin
               state_in = S_FSTART;
            end else if (k_ff == found_ff) begin
               state_in = S_ASTART;
            end else begin
               // weight = 2^32 / (distance + epsilon)
               div_start = 1'b1;
               div_num   = knn_pkg::DIV_NUM_W'(1) << 32;
               div_den   = knn_pkg::DIV_DEN_W'(dist_ff[ki]) +
                           knn_pkg::DIV_DEN_W'(knn_pkg::EPS_Q16);
               state_in  = S_WDIV;
            end
         end
         S_WDIV: begin
            if (div_done) begin
               wt_in[ki] = div_quot[knn_pkg::W_W-1:0];
               sumw_in   = sumw_ff + knn_pkg::SUMW_W'(div_quot[knn_pkg::W_W-1:0]);
               k_in      = k_ff + FND_W'(1);
               state_in  = S_WEIGHT;
            end
         end
         S_ASTART: begin
            acc_in   = '0;
            k_in     = '0;
            state_in = S_AREAD;
         end
         S_AREAD: begin
            state_in = (k_ff == found_ff) ? S_ONUM : S_AMUL;
         end
         S_AMUL: begin
            aprod_in = $signed(ang_rdata) * $signed({1'b0, wt_ff[ki]});
            state_in = S_AADD;
         end
         S_AADD: begin
            acc_in   = acc_ff + knn_pkg::ACC_W'(aprod_ff);
            k_in     = k_ff + FND_W'(1);
            state_in = S_AREAD;
         end
         S_ONUM: begin
            neg_in   = acc_ff[knn_pkg::ACC_W-1];
            mag_in   = acc_ff[knn_pkg::ACC_W-1] ? knn_pkg::ACC_W'(-acc_ff)
                                                : knn_pkg::ACC_W'(acc_ff);
            state_in = S_OSTART;
         end
         S_OSTART: begin
            // tenths = (20*|num| + den) / (2*den), den = sumw * 256
            div_start = 1'b1;
            div_num   = knn_pkg::DIV_NUM_W'({mag_ff, 4'b0}) +
                        knn_pkg::DIV_NUM_W'({mag_ff, 2'b0}) +
                        knn_pkg::DIV_NUM_W'({sumw_ff, 8'b0});
            div_den   = knn_pkg::DIV_DEN_W'({sumw_ff, 9'b0});
            state_in  = S_ODIV;
         end
         S_ODIV: begin
            if (div_done) begin
               tenths_in    = neg_ff ? knn_pkg::TENTHS_W'(-div_quot[knn_pkg::TENTHS_W-1:0])
                                     : div_quot[knn_pkg::TENTHS_W-1:0];
               mem_in       = 1'b1;
               last_in      = (s_ff == n_ff - CW'(1));
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_FSTART: begin
            // fallback: (160*s^2 + n^2) / (2*n^2)
            div_start = 1'b1;
            div_num   = knn_pkg::DIV_NUM_W'(32'(s_ff) * 32'(s_ff) * knn_pkg::FB_SCALE +
                                            32'(m2_ff));
            div_den   = knn_pkg::DIV_DEN_W'({m2_ff, 1'b0});
            state_in  = S_FDIV;
         end
         S_FDIV: begin
            if (div_done) begin
               tenths_in    = div_quot[knn_pkg::TENTHS_W-1:0];
               mem_in       = 1'b0;
               last_in      = (s_ff == n_ff - CW'(1));
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            // hold the beat until the receiver takes it
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  s_in     = s_ff + CW'(1);
                  state_in = mem_ff ? S_ASTART : S_FSTART;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rec_ff       <= '0;
         found_ff     <= '0;
         k_ff         <= '0;
         s_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rec_ff       <= rec_in;
         found_ff     <= found_in;
         k_ff         <= k_in;
         s_ff         <= s_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qcab_ff   <= qcab_in;
      qh_ff     <= qh_in;
      qt_ff     <= qt_in;
      n_ff      <= n_in;
      m2_ff     <= m2_in;
      dh_ff     <= dh_in;
      dt_ff     <= dt_in;
      hsq_ff    <= hsq_in;
      sq_ff     <= sq_in;
      dist_ff   <= dist_in;
      idx_ff    <= idx_in;
      wt_ff     <= wt_in;
      sumw_ff   <= sumw_in;
      aprod_ff  <= aprod_in;
      acc_ff    <= acc_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      tenths_ff <= tenths_in;
      mem_ff    <= mem_in;
      last_ff   <= last_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_splay_tenths = tenths_ff;
   assign rsp_from_memory  = mem_ff;
   assign rsp_last_result  = last_ff;
endmodule
`default_nettype wire

// ===== rtl/knn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module knn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/knn_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module knn_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire knn_pkg::div_num_type num,
   input  wire knn_pkg::div_den_type den,
   output logic                     done,
   output knn_pkg::div_num_type     quot
);
   localparam int NW = knn_pkg::DIV_NUM_W;
   localparam int DW = knn_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[NW-1]};
      if (start) begin
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next numerator bit, subtract when it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ===== rtl/knn_sqrt.sv =====
// Integer square root, two radicand bits per cycle.
`default_nettype none
module knn_sqrt (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire knn_pkg::radicand_type radicand,
   output logic                       done,
   output knn_pkg::root_type          root
);
   localparam int SW    = knn_pkg::SQ_W;
   localparam int STEPS = SW / 2;
   localparam int CW    = $clog2(STEPS + 1);

   logic [SW-1:0] v_ff, v_in;
   logic [SW-1:0] r_ff, r_in;
   logic [SW-1:0] bit_ff, bit_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] trial;

   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = r_ff + bit_ff;
      if (start) begin
         v_in    = radicand;
         r_in    = '0;
         bit_in  = SW'(1) << (SW - 2);
         cnt_in  = CW'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[knn_pkg::ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/knn_checker.sv =====
// Port-level checks of the splay predictor, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module knn_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic signed [11:0] rsp_splay_tenths,
   input wire logic        rsp_from_memory,
   input wire logic        rsp_last_result
);
   `KNN_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)
   `KNN_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_splay_tenths) && $stable(rsp_from_memory) && $stable(rsp_last_result))
   `KNN_ASSERT(a_busy_on_result, clock, reset, rsp_valid |-> !req_ready)
   `KNN_ASSERT(a_fallback_range, clock, reset, rsp_valid && !rsp_from_memory |-> !rsp_splay_tenths[11] && (rsp_splay_tenths <= 12'sd80))
endmodule

bind knn_idw_splay_predictor knn_checker u_knn_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_splay_tenths (rsp_splay_tenths),
   .rsp_from_memory  (rsp_from_memory),
   .rsp_last_result  (rsp_last_result)
);
`default_nettype wire
